// ===== rtl/core/lap3x3_pkg.sv =====
// ----------------------------------------------------------------------------
// lap3x3_pkg
// Shared types, register indexes and the per-channel Laplacian kernel.
// ----------------------------------------------------------------------------
package lap3x3_pkg;

  typedef logic [7:0] chan_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } pixel_t;

  typedef logic [1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_IMAGE_WIDTH  = 2'd0;
  localparam cfg_idx_t CFG_IMAGE_HEIGHT = 2'd1;

  localparam int CFG_DATA_W = 13;
  localparam int WIDTH_REG_W = 12;
  localparam int HEIGHT_REG_W = 13;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 12'd640;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;

  localparam logic [1:0] CH_BLUE  = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_RED   = 2'd2;

  function automatic chan_t chan_of(pixel_t p, logic [1:0] ch);
    chan_t v;
    unique case (ch)
      CH_BLUE:  v = p.blue;
      CH_GREEN: v = p.green;
      CH_RED:   v = p.red;
      default:  v = p.blue;
    endcase
    return v;
  endfunction

  // 8*center minus the eight neighbors, clamped to 0..255
  function automatic chan_t lap_clamp(chan_t ctr, logic [7:0][7:0] nb);
    logic [10:0]        sum;
    logic signed [12:0] acc;
    chan_t              res;
    sum = '0;
    for (int i = 0; i < 8; i++) begin
      sum = sum + 11'(nb[i]);
    end
    acc = $signed({2'b00, ctr, 3'b000}) - $signed({2'b00, sum});
    if (acc < 0) begin
      res = 8'h00;
    end else if (acc > 13'sd255) begin
      res = 8'hff;
    end else begin
      res = acc[7:0];
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/lap3x3_ram.sv =====
// ----------------------------------------------------------------------------
// lap3x3_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lap3x3_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/laplacian_3x3_edge_filter_unit.sv =====
// ----------------------------------------------------------------------------
// laplacian_3x3_edge_filter_unit
// 3x3 Laplacian over a raster BGR stream with two line buffers.
//
//   port group   dir  handshake          payload
//   in_*         in   in_valid/in_stall  in_blue, in_green, in_red
//   out_*        out  out_valid/out_stall out_blue/green/red, center row/col
//   cfg_*        in   cfg_wr_en          cfg_index, cfg_wdata
//
// One item per cycle sustained while the output does not stall. Each item is
// registered with its line buffer read, then kernel and clamp load the output
// register. Line buffers are not cleared; each entry feeding a result is
// written earlier in the frame. Reset clears counters and pipeline valids
// and loads 640x480 into the size registers. A stalled output blocks input only while the staged item has a result.
// ----------------------------------------------------------------------------
module laplacian_3x3_edge_filter_unit #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  lap3x3_pkg::chan_t                     in_blue,
  input  lap3x3_pkg::chan_t                     in_green,
  input  lap3x3_pkg::chan_t                     in_red,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output lap3x3_pkg::chan_t                     out_blue,
  output lap3x3_pkg::chan_t                     out_green,
  output lap3x3_pkg::chan_t                     out_red,
  output logic [$clog2(MAX_HEIGHT)-1:0]         out_center_row,
  output logic [$clog2(MAX_WIDTH)-1:0]          out_center_col,
  input  logic                                  cfg_wr_en,
  input  lap3x3_pkg::cfg_idx_t                  cfg_index,
  input  logic [lap3x3_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int WCMP = (CW + 1 > lap3x3_pkg::WIDTH_REG_W) ? CW + 1
                                                           : lap3x3_pkg::WIDTH_REG_W;
  localparam int HCMP = (RW + 1 > lap3x3_pkg::HEIGHT_REG_W) ? RW + 1
                                                            : lap3x3_pkg::HEIGHT_REG_W;

  // configuration
  logic [lap3x3_pkg::WIDTH_REG_W-1:0]  width_r;
  logic [lap3x3_pkg::HEIGHT_REG_W-1:0] height_r;
  logic [CW:0] eff_w;
  logic [RW:0] eff_h;

  // raster position of the next input
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;

  // read stage
  logic               s1_v_r;
  lap3x3_pkg::pixel_t s1_pix_r;
  logic [CW-1:0]      s1_col_r;
  logic [RW-1:0]      s1_row_r;
  lap3x3_pkg::pixel_t up_px, mid_px;
  logic [23:0]        up_raw, mid_raw;

  // window: column 0 is oldest; top, mid, bottom
  lap3x3_pkg::pixel_t win0_top_r, win0_mid_r, win0_bot_r;
  lap3x3_pkg::pixel_t win1_top_r, win1_mid_r, win1_bot_r;

  logic out_valid_r;
  lap3x3_pkg::chan_t out_blue_r, out_green_r, out_red_r;
  logic [RW-1:0] out_row_r;
  logic [CW-1:0] out_col_r;

  logic in_acc, out_free, s1_hit, s1_adv;
  lap3x3_pkg::chan_t lap_res [3];

  always_comb begin
    if (width_r < lap3x3_pkg::WIDTH_REG_W'(3)) begin
      eff_w = (CW + 1)'(3);
    end else if (WCMP'(width_r) > WCMP'(MAX_WIDTH)) begin
      eff_w = (CW + 1)'(MAX_WIDTH);
    end else begin
      eff_w = (CW + 1)'(width_r);
    end
    if (height_r < lap3x3_pkg::HEIGHT_REG_W'(3)) begin
      eff_h = (RW + 1)'(3);
    end else if (HCMP'(height_r) > HCMP'(MAX_HEIGHT)) begin
      eff_h = (RW + 1)'(MAX_HEIGHT);
    end else begin
      eff_h = (RW + 1)'(height_r);
    end
  end

  assign out_free = !out_valid_r || !out_stall;
  assign s1_hit   = (s1_row_r >= RW'(2)) && (s1_col_r >= CW'(2));
  assign s1_adv   = s1_v_r && (!s1_hit || out_free);
  assign in_stall = s1_v_r && !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if ({1'b0, col_r} + (CW + 1)'(1) == eff_w) begin
      col_nxt = '0;
      if ({1'b0, row_r} + (RW + 1)'(1) == eff_h) begin
        row_nxt = '0;
      end else begin
        row_nxt = row_r + RW'(1);
      end
    end else begin
      col_nxt = col_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= lap3x3_pkg::WIDTH_RESET;
      height_r <= lap3x3_pkg::HEIGHT_RESET;
      col_r    <= '0;
      row_r    <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        lap3x3_pkg::CFG_IMAGE_WIDTH: begin
          width_r <= cfg_wdata[lap3x3_pkg::WIDTH_REG_W-1:0];
          col_r   <= '0;
          row_r   <= '0;
        end
        lap3x3_pkg::CFG_IMAGE_HEIGHT: begin
          height_r <= cfg_wdata;
          col_r    <= '0;
          row_r    <= '0;
        end
        default: begin
        end
      endcase
    end else if (in_acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  lap3x3_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_upper_ram (
    .clk     (clk),
    .wr_en   (s1_adv),
    .wr_addr (s1_col_r),
    .wr_data (mid_raw),
    .rd_en   (in_acc),
    .rd_addr (col_r),
    .rd_data (up_raw)
  );

  lap3x3_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_middle_ram (
    .clk     (clk),
    .wr_en   (s1_adv),
    .wr_addr (s1_col_r),
    .wr_data (s1_pix_r),
    .rd_en   (in_acc),
    .rd_addr (col_r),
    .rd_data (mid_raw)
  );

  assign up_px  = up_raw;
  assign mid_px = mid_raw;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_acc) begin
      s1_v_r <= 1'b1;
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix_r <= '{red: in_red, green: in_green, blue: in_blue};
      s1_col_r <= col_r;
      s1_row_r <= row_r;
    end
    if (s1_adv) begin
      win0_top_r <= win1_top_r;
      win0_mid_r <= win1_mid_r;
      win0_bot_r <= win1_bot_r;
      win1_top_r <= up_px;
      win1_mid_r <= mid_px;
      win1_bot_r <= s1_pix_r;
    end
  end

  always_comb begin
    logic [7:0][7:0] nb;
    for (int ch = 0; ch < 3; ch++) begin
      nb[0] = lap3x3_pkg::chan_of(win0_top_r, 2'(ch));
      nb[1] = lap3x3_pkg::chan_of(win0_mid_r, 2'(ch));
      nb[2] = lap3x3_pkg::chan_of(win0_bot_r, 2'(ch));
      nb[3] = lap3x3_pkg::chan_of(win1_top_r, 2'(ch));
      nb[4] = lap3x3_pkg::chan_of(win1_bot_r, 2'(ch));
      nb[5] = lap3x3_pkg::chan_of(up_px, 2'(ch));
      nb[6] = lap3x3_pkg::chan_of(mid_px, 2'(ch));
      nb[7] = lap3x3_pkg::chan_of(s1_pix_r, 2'(ch));
      lap_res[ch] = lap3x3_pkg::lap_clamp(lap3x3_pkg::chan_of(win1_mid_r, 2'(ch)), nb);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_hit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_hit) begin
      out_blue_r  <= lap_res[0];
      out_green_r <= lap_res[1];
      out_red_r   <= lap_res[2];
      out_row_r   <= s1_row_r - RW'(1);
      out_col_r   <= s1_col_r - CW'(1);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_blue       = out_blue_r;
  assign out_green      = out_green_r;
  assign out_red        = out_red_r;
  assign out_center_row = out_row_r;
  assign out_center_col = out_col_r;

  a_hit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && s1_hit |-> !(out_valid_r && out_stall))
    else $error("result overwrote a waiting result");

  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, col_r} < eff_w)
    else $error("column counter beyond image width");

  a_stall_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_v_r && s1_hit)
    else $error("input stalled without a pending result");

  a_center_interior: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_row_r != '0) && (out_col_r != '0))
    else $error("border pixel produced a result");

endmodule
